>>> rtl/core/dfr_pkg.sv
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared types and constants for the delimited frame receiver: defaults,
// register indexes, controller states and the controller/datapath signals.
// ----------------------------------------------------------------------------
package dfr_pkg;

  // Default frame buffer length (frame holds at most FRAME_LEN-1 bytes)
  localparam int unsigned FrameLenDefault = 32;

  // Field widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned FrameNumW = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  // Register reset values
  localparam logic [ByteW-1:0] StartByteRst = 8'h02;
  localparam logic [ByteW-1:0] EndByteRst   = 8'h03;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_BYTE = 1'b0,
    CFG_END_BYTE   = 1'b1
  } cfg_reg_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COLLECT,
    ST_EMIT
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic store_first;  // store byte at position 0, restart fill
    logic store;        // store byte at fill position, advance fill
    logic drop;         // discard the frame
    logic finish;       // close the frame and start readout
    logic rd_next;      // advance readout position
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_start;     // incoming byte matches start byte
    logic is_end;       // incoming byte matches end byte
    logic at_limit;     // fill position reached FRAME_LEN-2
    logic rd_last;      // readout is on the last byte of the frame
  } dp_status_t;

endpackage

>>> rtl/core/dfr_in_if.sv
// ----------------------------------------------------------------------------
// dfr_in_if
// Received byte channel: valid/ready handshake with one byte per item.
// ----------------------------------------------------------------------------
interface dfr_in_if;

  logic                         valid;
  logic                         ready;
  logic [dfr_pkg::ByteW-1:0]    rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);

endinterface

>>> rtl/core/dfr_out_if.sv
// ----------------------------------------------------------------------------
// dfr_out_if
// Frame byte channel: valid/ready handshake, one frame byte per item.
// ----------------------------------------------------------------------------
interface dfr_out_if;

  logic                           valid;
  logic                           ready;
  logic [dfr_pkg::ByteW-1:0]      frame_byte;
  logic                           last;
  logic [dfr_pkg::FrameNumW-1:0]  frame_number;

  modport source (output valid, output frame_byte, output last, output frame_number,
                  input ready);
  modport sink   (input valid, input frame_byte, input last, input frame_number,
                  output ready);

endinterface

>>> rtl/core/delimited_frame_receiver_top.sv
// Latency: the first frame byte is offered the cycle after the end byte is accepted.
// Throughput: one received byte per cycle while waiting or collecting; a completed
// frame is read out of the frame buffer at one byte per cycle while the sink is
// ready, and during the readout no received byte is accepted.
// Reset: start byte 0x02, end byte 0x03, receiver idle, frame counter zero;
// the frame buffer is not cleared.
// ----------------------------------------------------------------------------
// delimited_frame_receiver_top
// Start/end delimited frame receiver: collects bytes from the start delimiter
// through the end delimiter and emits the completed frame with its frame number.
// ----------------------------------------------------------------------------
module delimited_frame_receiver_top #(
  parameter int unsigned FRAME_LEN = dfr_pkg::FrameLenDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dfr_pkg::CfgDataW-1:0] cfg_data_i,
  dfr_in_if.sink                       in_if,
  dfr_out_if.source                    out_if
);

  dfr_pkg::dp_cmd_t    cmd;
  dfr_pkg::dp_status_t status;

  // Control state machine
  dfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Frame buffer and counters
  dfr_datapath #(
    .FRAME_LEN (FRAME_LEN)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .rx_byte_i      (in_if.rx_byte),
    .cmd_i          (cmd),
    .status_o       (status),
    .frame_byte_o   (out_if.frame_byte),
    .last_o         (out_if.last),
    .frame_number_o (out_if.frame_number)
  );

endmodule

>>> rtl/core/dfr_ctrl.sv
// ----------------------------------------------------------------------------
// dfr_ctrl
// Frame controller: waits for the start byte, collects, drops overlong
// frames and sequences the readout of a completed frame.
// ----------------------------------------------------------------------------
module dfr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  dfr_pkg::dp_status_t status_i,
  output dfr_pkg::dp_cmd_t    cmd_o
);

  dfr_pkg::state_e state_q, state_d;
  logic            in_acc;
  logic            out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dfr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dfr_pkg::ST_IDLE: begin
        if (in_acc && status_i.is_start) begin
          state_d = dfr_pkg::ST_COLLECT;
        end
      end
      dfr_pkg::ST_COLLECT: begin
        if (in_acc && !status_i.is_start) begin
          if (status_i.is_end) begin
            state_d = dfr_pkg::ST_EMIT;
          end else if (status_i.at_limit) begin
            state_d = dfr_pkg::ST_IDLE;
          end
        end
      end
      dfr_pkg::ST_EMIT: begin
        if (out_acc && status_i.rd_last) begin
          state_d = dfr_pkg::ST_IDLE;
        end
      end
      default: state_d = dfr_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath commands; ready and valid are constant per state,
  // so the handshake reduces to the other side's signal here
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      dfr_pkg::ST_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.store_first = in_valid_i && status_i.is_start;
      end
      dfr_pkg::ST_COLLECT: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (status_i.is_start) begin
            cmd_o.store_first = 1'b1;
          end else if (status_i.is_end) begin
            cmd_o.store  = 1'b1;
            cmd_o.finish = 1'b1;
          end else if (status_i.at_limit) begin
            cmd_o.drop = 1'b1;
          end else begin
            cmd_o.store = 1'b1;
          end
        end
      end
      dfr_pkg::ST_EMIT: begin
        out_valid_o   = 1'b1;
        cmd_o.rd_next = out_ready_i && !status_i.rd_last;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/core/dfr_datapath.sv
// ----------------------------------------------------------------------------
// dfr_datapath
// Frame datapath: delimiter registers, frame buffer, fill and readout
// positions, frame counter and byte compare logic.
// ----------------------------------------------------------------------------
module dfr_datapath #(
  parameter int unsigned FRAME_LEN = dfr_pkg::FrameLenDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dfr_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [dfr_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic [dfr_pkg::ByteW-1:0]       rx_byte_i,
  input  dfr_pkg::dp_cmd_t                cmd_i,
  output dfr_pkg::dp_status_t             status_o,
  output logic [dfr_pkg::ByteW-1:0]       frame_byte_o,
  output logic                            last_o,
  output logic [dfr_pkg::FrameNumW-1:0]   frame_number_o
);

  localparam int unsigned IdxW  = $clog2(FRAME_LEN);
  localparam int unsigned Limit = FRAME_LEN - 2;

  logic [dfr_pkg::ByteW-1:0]     start_byte_q;
  logic [dfr_pkg::ByteW-1:0]     end_byte_q;
  logic [dfr_pkg::ByteW-1:0]     mem_q [FRAME_LEN];
  logic [IdxW-1:0]               fill_q, fill_d;
  logic [IdxW-1:0]               rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]               last_idx_q;
  logic [IdxW-1:0]               wr_addr;
  logic                          wr_en;
  logic [dfr_pkg::ByteW-1:0]     rd_data_q;
  logic [dfr_pkg::FrameNumW-1:0] frames_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= dfr_pkg::StartByteRst;
      end_byte_q   <= dfr_pkg::EndByteRst;
    end else if (cfg_we_i) begin
      case (dfr_pkg::cfg_reg_e'(cfg_idx_i))
        dfr_pkg::CFG_START_BYTE: start_byte_q <= cfg_data_i[dfr_pkg::ByteW-1:0];
        dfr_pkg::CFG_END_BYTE:   end_byte_q   <= cfg_data_i[dfr_pkg::ByteW-1:0];
        default: ;
      endcase
    end
  end

  // Byte compares for the controller
  assign status_o.is_start = (rx_byte_i == start_byte_q);
  assign status_o.is_end   = (rx_byte_i == end_byte_q);
  assign status_o.at_limit = (fill_q >= IdxW'(Limit));
  assign status_o.rd_last  = (rd_idx_q == last_idx_q);

  // Fill position: restart at one after the start byte, clear on drop or finish, advance on store
  always_comb begin
    fill_d = fill_q;
    if (cmd_i.store_first) begin
      fill_d = IdxW'(1);
    end else if (cmd_i.drop || cmd_i.finish) begin
      fill_d = '0;
    end else if (cmd_i.store) begin
      fill_d = fill_q + IdxW'(1);
    end
  end

  // Readout position: rewind when a frame closes, advance per item taken but the last
  always_comb begin
    rd_idx_d = rd_idx_q;
    if (cmd_i.finish) begin
      rd_idx_d = '0;
    end else if (cmd_i.rd_next) begin
      rd_idx_d = rd_idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      rd_idx_q   <= '0;
      last_idx_q <= '0;
      frames_q   <= '0;
    end else begin
      fill_q   <= fill_d;
      rd_idx_q <= rd_idx_d;
      if (cmd_i.finish) begin
        last_idx_q <= fill_q;
        frames_q   <= frames_q + dfr_pkg::FrameNumW'(1);
      end
    end
  end

  // Frame buffer: one write port, registered read at the next readout position
  assign wr_en   = cmd_i.store_first || cmd_i.store;
  assign wr_addr = cmd_i.store_first ? '0 : fill_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= rx_byte_i;
    end
    rd_data_q <= mem_q[rd_idx_d];
  end

  assign frame_byte_o   = rd_data_q;
  assign last_o         = status_o.rd_last;
  assign frame_number_o = frames_q;

endmodule
